// ===== hw/rtl/fa2p_pkg.sv =====
// ----------------------------------------------------------------------------
// fa2p_pkg
// shared types and constants of the polynomial four-quadrant arctangent
// ----------------------------------------------------------------------------
`default_nettype none

package fa2p_pkg;

  localparam int unsigned INPUT_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned FRAC_RATIO      = 16;
  localparam int unsigned LIMIT_W         = 16;
  localparam int unsigned ANGLE_W         = 16;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned APB_ADDR_W      = 3;

  // register index, taken from paddr[2]
  localparam logic REG_NEAR_ZERO_LIMIT = 1'b0;

  // first-octant cubic, 16 fraction bits
  localparam logic signed [17:0] COEF_C1 = 18'sd65887;
  localparam logic signed [17:0] COEF_C2 = -18'sd5826;
  localparam logic signed [17:0] COEF_C3 = -18'sd8865;

  // angles in q3.13
  localparam logic signed [ANGLE_W-1:0] ANG_PI      = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] ANG_HALF_PI = 16'sd12868;

  typedef enum logic [1:0] {
    KIND_Y_ZERO = 2'd0,
    KIND_X_ZERO = 2'd1,
    KIND_RATIO  = 2'd2
  } kind_e;

  typedef struct packed {
    logic  yneg;
    logic  xneg;
    logic  inv;
    logic  eq;
    kind_e kind;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fast_atan2_polynomial.sv =====
// throughput: one request per cycle while the result is not stalled, through the 16-stage one-bit
//   divider and the 4-stage polynomial pipeline behind a 2-entry queue
// reset: clears all valid flags, queue pointers and near_zero_limit (to 0)
// ----------------------------------------------------------------------------
// fast_atan2_polynomial
// four-quadrant arctangent of a q16.16 point by cubic polynomial, q3.13 result
// ----------------------------------------------------------------------------
`default_nettype none

module fast_atan2_polynomial #(
  parameter int unsigned INPUT_WIDTH = fa2p_pkg::INPUT_WIDTH_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [INPUT_WIDTH-1:0]          y_coord_i,
  input  wire logic signed [INPUT_WIDTH-1:0]          x_coord_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [fa2p_pkg::ANGLE_W-1:0]         angle_o,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [fa2p_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire logic [fa2p_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [fa2p_pkg::APB_DATA_W-1:0]             prdata,
  output logic                                        pready
);

  localparam int unsigned CTRL_W = $bits(fa2p_pkg::ctrl_t);
  localparam int unsigned DW     = CTRL_W + 2 * INPUT_WIDTH;

  logic [fa2p_pkg::LIMIT_W-1:0]      limit_q;
  logic                              cfg_wr;
  logic                              q_full, q_empty, push, pop, en;
  fa2p_pkg::ctrl_t                   f_ctrl, q_ctrl, d_ctrl;
  logic [INPUT_WIDTH-1:0]            f_small, f_large, q_small, q_large;
  logic [DW-1:0]                     q_din, q_dout;
  logic                              d_vld;
  logic [fa2p_pkg::FRAC_RATIO-1:0]   d_quo;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == fa2p_pkg::REG_NEAR_ZERO_LIMIT);
  assign prdata = (paddr[2] == fa2p_pkg::REG_NEAR_ZERO_LIMIT)
                  ? fa2p_pkg::APB_DATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_wr) begin
      limit_q <= pwdata[fa2p_pkg::LIMIT_W-1:0];
    end
  end

  // back pipeline advances unless the result register is held
  assign en  = !(out_valid_o && out_stall_i);
  assign pop = en && !q_empty;

  fa2p_front #(
    .W (INPUT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .y_coord_i  (y_coord_i),
    .x_coord_i  (x_coord_i),
    .limit_i    (limit_q),
    .full_i     (q_full),
    .push_o     (push),
    .ctrl_o     (f_ctrl),
    .small_o    (f_small),
    .large_o    (f_large)
  );

  assign q_din   = {f_ctrl, f_small, f_large};
  assign q_ctrl  = fa2p_pkg::ctrl_t'(q_dout[DW-1 -: CTRL_W]);
  assign q_small = q_dout[2*INPUT_WIDTH-1:INPUT_WIDTH];
  assign q_large = q_dout[INPUT_WIDTH-1:0];

  fa2p_queue #(
    .DEPTH (fa2p_pkg::QUEUE_DEPTH),
    .DW    (DW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (q_din),
    .pop_i   (pop),
    .dout_o  (q_dout),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fa2p_div #(
    .W (INPUT_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (!q_empty),
    .ctrl_i  (q_ctrl),
    .small_i (q_small),
    .large_i (q_large),
    .vld_o   (d_vld),
    .ctrl_o  (d_ctrl),
    .quo_o   (d_quo)
  );

  fa2p_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (d_vld),
    .ctrl_i  (d_ctrl),
    .quo_i   (d_quo),
    .vld_o   (out_valid_o),
    .angle_o (angle_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fa2p_front.sv =====
// ----------------------------------------------------------------------------
// fa2p_front
// request register, magnitudes and classification of each point
// ----------------------------------------------------------------------------
`default_nettype none

module fa2p_front #(
  parameter int unsigned W = fa2p_pkg::INPUT_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [W-1:0]            y_coord_i,
  input  wire logic signed [W-1:0]            x_coord_i,
  input  wire logic [fa2p_pkg::LIMIT_W-1:0]   limit_i,
  input  wire logic                           full_i,
  output logic                                push_o,
  output fa2p_pkg::ctrl_t                     ctrl_o,
  output logic [W-1:0]                        small_o,
  output logic [W-1:0]                        large_o
);

  localparam int unsigned CW = (W > fa2p_pkg::LIMIT_W) ? W : fa2p_pkg::LIMIT_W;

  logic                 vld_q, vld_d;
  logic [W-1:0]         y_q, x_q;
  logic                 load;
  logic                 yneg, xneg;
  logic [W-1:0]         ay, ax;
  logic [CW-1:0]        ay_ext, ax_ext, lim_ext;

  assign in_stall_o = vld_q && full_i;
  assign load       = !in_stall_o;
  assign push_o     = vld_q && !full_i;
  assign vld_d      = load ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      y_q <= y_coord_i;
      x_q <= x_coord_i;
    end
  end

  always_comb begin
    yneg    = y_q[W-1];
    xneg    = x_q[W-1];
    ay      = yneg ? (~y_q + W'(1)) : y_q;
    ax      = xneg ? (~x_q + W'(1)) : x_q;
    ay_ext  = CW'(ay);
    ax_ext  = CW'(ax);
    lim_ext = CW'(limit_i);

    ctrl_o.yneg = yneg;
    ctrl_o.xneg = xneg;
    ctrl_o.inv  = ax < ay;
    ctrl_o.eq   = ax == ay;
    if (ay_ext <= lim_ext) begin
      ctrl_o.kind = fa2p_pkg::KIND_Y_ZERO;
    end else if (ax_ext <= lim_ext) begin
      ctrl_o.kind = fa2p_pkg::KIND_X_ZERO;
    end else begin
      ctrl_o.kind = fa2p_pkg::KIND_RATIO;
    end
    small_o = (ax < ay) ? ax : ay;
    large_o = (ax < ay) ? ay : ax;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fa2p_queue.sv =====
// ----------------------------------------------------------------------------
// fa2p_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fa2p_queue #(
  parameter int unsigned DEPTH = fa2p_pkg::QUEUE_DEPTH,
  parameter int unsigned DW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] din_i,
  input  wire logic          pop_i,
  output logic [DW-1:0]      dout_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == NW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fa2p_div.sv =====
// ----------------------------------------------------------------------------
// fa2p_div
// pipelined ratio divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module fa2p_div #(
  parameter int unsigned W = fa2p_pkg::INPUT_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             vld_i,
  input  wire fa2p_pkg::ctrl_t                  ctrl_i,
  input  wire logic [W-1:0]                     small_i,
  input  wire logic [W-1:0]                     large_i,
  output logic                                  vld_o,
  output fa2p_pkg::ctrl_t                       ctrl_o,
  output logic [fa2p_pkg::FRAC_RATIO-1:0]       quo_o
);

  localparam int unsigned NS = fa2p_pkg::FRAC_RATIO;

  logic                  vld_q   [NS];
  fa2p_pkg::ctrl_t       ctrl_q  [NS];
  logic [W-1:0]          rem_q   [NS];
  logic [W-1:0]          large_q [NS];
  logic [NS-1:0]         quo_q   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic            vld_in;
    fa2p_pkg::ctrl_t ctrl_in;
    logic [W-1:0]    rem_in, large_in;
    logic [NS-1:0]   quo_in;
    logic [W:0]      two;
    logic            ge;
    logic [W:0]      diff;

    if (k == 0) begin : g_first
      assign vld_in   = vld_i;
      assign ctrl_in  = ctrl_i;
      assign rem_in   = small_i;
      assign large_in = large_i;
      assign quo_in   = '0;
    end else begin : g_next
      assign vld_in   = vld_q[k-1];
      assign ctrl_in  = ctrl_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign large_in = large_q[k-1];
      assign quo_in   = quo_q[k-1];
    end

    assign two  = {rem_in, 1'b0};
    assign ge   = two >= {1'b0, large_in};
    assign diff = two - {1'b0, large_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctrl_q[k]  <= ctrl_in;
        large_q[k] <= large_in;
        rem_q[k]   <= ge ? diff[W-1:0] : two[W-1:0];
        quo_q[k]   <= {quo_in[NS-2:0], ge};
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign ctrl_o = ctrl_q[NS-1];
  assign quo_o  = quo_q[NS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/fa2p_poly.sv =====
// ----------------------------------------------------------------------------
// fa2p_poly
// cubic evaluation, quadrant folding, near-axis cases and result register
// ----------------------------------------------------------------------------
`default_nettype none

module fa2p_poly (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 en_i,
  input  wire logic                                 vld_i,
  input  wire fa2p_pkg::ctrl_t                      ctrl_i,
  input  wire logic [fa2p_pkg::FRAC_RATIO-1:0]      quo_i,
  output logic                                      vld_o,
  output logic signed [fa2p_pkg::ANGLE_W-1:0]       angle_o
);

  localparam int unsigned VW = fa2p_pkg::FRAC_RATIO + 1;

  logic                        vld1_q, vld2_q, vld3_q, vld4_q;
  fa2p_pkg::ctrl_t             ctrl1_q, ctrl2_q, ctrl3_q;
  logic [VW-1:0]               v_d, v1_q, v2_q;
  logic signed [31:0]          p1_d, p1_q, p2_d, p2_q;
  logic signed [34:0]          p3_d, p3_q;
  logic signed [15:0]          t2;
  logic signed [17:0]          t1;
  logic signed [16:0]          a0, a1, a2, a3;
  logic signed [fa2p_pkg::ANGLE_W-1:0] angle_d, angle_q;

  always_comb begin
    v_d  = ctrl_i.eq ? {1'b1, {(VW-1){1'b0}}} : {1'b0, quo_i};
    p1_d = 32'(fa2p_pkg::COEF_C3 * $signed({1'b0, v_d}));
    t2   = 16'(fa2p_pkg::COEF_C2 + ((p1_q + 32'sd32768) >>> 16));
    p2_d = 32'(t2 * $signed({1'b0, v1_q}));
    t1   = 18'(fa2p_pkg::COEF_C1 + ((p2_q + 32'sd32768) >>> 16));
    p3_d = 35'(t1 * $signed({1'b0, v2_q}));
  end

  always_comb begin
    a0 = 17'((p3_q + 35'sd262144) >>> 19);
    a1 = ctrl3_q.inv ? (17'(fa2p_pkg::ANG_HALF_PI) - a0) : a0;
    a2 = ctrl3_q.yneg ? -a1 : a1;
    if (ctrl3_q.xneg) begin
      a3 = ctrl3_q.yneg ? (-17'(fa2p_pkg::ANG_PI) - a2) : (17'(fa2p_pkg::ANG_PI) - a2);
    end else begin
      a3 = a2;
    end
    unique case (ctrl3_q.kind)
      fa2p_pkg::KIND_Y_ZERO: angle_d = ctrl3_q.xneg ? fa2p_pkg::ANG_PI : '0;
      fa2p_pkg::KIND_X_ZERO: angle_d = ctrl3_q.yneg ? -fa2p_pkg::ANG_HALF_PI
                                                    : fa2p_pkg::ANG_HALF_PI;
      fa2p_pkg::KIND_RATIO:  angle_d = a3[fa2p_pkg::ANGLE_W-1:0];
      default:               angle_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl1_q <= ctrl_i;
      v1_q    <= v_d;
      p1_q    <= p1_d;
      ctrl2_q <= ctrl1_q;
      v2_q    <= v1_q;
      p2_q    <= p2_d;
      ctrl3_q <= ctrl2_q;
      p3_q    <= p3_d;
      angle_q <= angle_d;
    end
  end

  assign vld_o   = vld4_q;
  assign angle_o = angle_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fa2p_checker.sv =====
// ----------------------------------------------------------------------------
// fa2p_checker
// port-level checks of the arctangent block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module fa2p_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  out_valid_o,
  input wire logic                                  out_stall_i,
  input wire logic signed [fa2p_pkg::ANGLE_W-1:0]   angle_o,
  input wire logic                                  psel,
  input wire logic                                  penable,
  input wire logic                                  pwrite,
  input wire logic                                  pready,
  input wire logic [fa2p_pkg::APB_ADDR_W-1:0]       paddr,
  input wire logic [fa2p_pkg::APB_DATA_W-1:0]       pwdata,
  input wire logic [fa2p_pkg::APB_DATA_W-1:0]       prdata
);

  // held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // held result keeps its angle
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(angle_o))
    else $error("result changed while stalled");

  // angle within minus pi to pi
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_o >= -fa2p_pkg::ANG_PI) && (angle_o <= fa2p_pkg::ANG_PI))
    else $error("angle out of range");

  // limit register reads back what was written
  a_limit_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready
     && (paddr[2] == fa2p_pkg::REG_NEAR_ZERO_LIMIT))
    ##1 (paddr[2] == fa2p_pkg::REG_NEAR_ZERO_LIMIT)
    |-> prdata == fa2p_pkg::APB_DATA_W'($past(pwdata[fa2p_pkg::LIMIT_W-1:0])))
    else $error("limit register readback mismatch");

endmodule

bind fast_atan2_polynomial fa2p_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .angle_o     (angle_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .pready      (pready),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

`default_nettype wire
